// ----- rtl/ucfp_pkg.sv -----
// ============================================================================
// UDP CSI frame parser package
// Shared beat types, header offsets and protocol constants.
// ============================================================================
package ucfp_pkg;

  localparam int unsigned MAX_SAMPLES_DEF   = 256;
  localparam int unsigned PAYLOAD_START_DEF = 60;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  L4_PROTO_UDP  = 8'd17;

  localparam logic [15:0] OFS_ETYPE_HI = 16'd12;
  localparam logic [15:0] OFS_ETYPE_LO = 16'd13;
  localparam logic [15:0] OFS_L4_PROTO = 16'd23;
  localparam logic [15:0] OFS_PORT_HI  = 16'd36;
  localparam logic [15:0] OFS_PORT_LO  = 16'd37;
  localparam logic [15:0] OFS_RSSI     = 16'd44;
  localparam logic [15:0] OFS_SEQ_LO   = 16'd52;
  localparam logic [15:0] OFS_SEQ_HI   = 16'd53;
  localparam logic [15:0] OFS_CORE     = 16'd54;
  localparam logic [15:0] OFS_CHAN_LO  = 16'd56;
  localparam logic [15:0] OFS_CHAN_HI  = 16'd57;
  localparam logic [15:0] IDX_MAX      = 16'hFFFF;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_META   = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic               sample_frame_end;
    logic signed [7:0]  signal_strength;
    logic [15:0]        sequence_number;
    logic [7:0]         core_stream;
    logic [15:0]        channel_spec;
    logic [8:0]         sample_count;
    logic               run_last;
  } out_beat_t;

  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_beat_t res0;
    out_beat_t res1;
  } res_push_t;

endpackage

// ----- rtl/ucfp_parse.sv -----
// ============================================================================
// UDP CSI frame parser: input register and byte parser
// Holds one accepted beat, updates the per-frame state and forms up to two
// results for that beat in a single pass.
// ============================================================================
module ucfp_parse import ucfp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int unsigned PAYLOAD_START = PAYLOAD_START_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  input  logic [15:0] dest_port_i,
  input  logic        room_i,
  output res_push_t   push_o
);

  localparam int unsigned SDW = $clog2(MAX_SAMPLES + 1);

  logic              in_vld_q;
  in_beat_t          in_beat_q;
  logic              acc, adv;

  logic [15:0]       idx_q, idx_d;
  logic [15:0]       etype_q, etype_d;
  logic [7:0]        proto_q, proto_d;
  logic [7:0]        port_hi_q, port_hi_d;
  logic              kept_q, kept_d;
  logic [7:0]        rssi_q, rssi_d;
  logic [15:0]       seq_q, seq_d;
  logic [7:0]        core_q, core_d;
  logic [15:0]       chan_q, chan_d;
  logic [SDW-1:0]    done_q, done_d;
  logic [7:0]        held0_q, held0_d, held1_q, held1_d, held2_q, held2_d;
  logic [1:0]        phase_q, phase_d;
  logic              smp_fire, meta_fire;
  logic [SDW+8:0]    cnt_ext;
  out_beat_t         smp_res, meta_res;
  logic [7:0]        b;
  logic              last;

  assign adv        = in_vld_q & room_i;
  assign in_stall_o = in_vld_q & ~room_i;
  assign acc        = in_valid_i & ~in_stall_o;
  assign b          = in_beat_q.frame_byte;
  assign last       = in_beat_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= acc | (in_vld_q & ~adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_beat_q <= in_beat_i;
    end
  end

  always_comb begin
    idx_d     = idx_q;
    etype_d   = etype_q;
    proto_d   = proto_q;
    port_hi_d = port_hi_q;
    kept_d    = kept_q;
    rssi_d    = rssi_q;
    seq_d     = seq_q;
    core_d    = core_q;
    chan_d    = chan_q;
    done_d    = done_q;
    held0_d   = held0_q;
    held1_d   = held1_q;
    held2_d   = held2_q;
    phase_d   = phase_q;
    smp_fire  = 1'b0;
    priority if (idx_q == OFS_ETYPE_HI) begin
      etype_d[15:8] = b;
    end else if (idx_q == OFS_ETYPE_LO) begin
      etype_d[7:0] = b;
    end else if (idx_q == OFS_L4_PROTO) begin
      proto_d = b;
    end else if (idx_q == OFS_PORT_HI) begin
      port_hi_d = b;
    end else if (idx_q == OFS_PORT_LO) begin
      kept_d = (etype_q == ETH_TYPE_IPV4) && (proto_q == L4_PROTO_UDP) &&
               ({port_hi_q, b} == dest_port_i);
    end else if (idx_q == OFS_RSSI) begin
      rssi_d = b;
    end else if (idx_q == OFS_SEQ_LO) begin
      seq_d[7:0] = b;
    end else if (idx_q == OFS_SEQ_HI) begin
      seq_d[15:8] = b;
    end else if (idx_q == OFS_CORE) begin
      core_d = b;
    end else if (idx_q == OFS_CHAN_LO) begin
      chan_d[7:0] = b;
    end else if (idx_q == OFS_CHAN_HI) begin
      chan_d[15:8] = b;
    end else if ((idx_q >= 16'(PAYLOAD_START)) && kept_q &&
                 (done_q < SDW'(MAX_SAMPLES))) begin
      unique case (phase_q)
        2'd0: begin
          held0_d = b;
          phase_d = 2'd1;
        end
        2'd1: begin
          held1_d = b;
          phase_d = 2'd2;
        end
        2'd2: begin
          held2_d = b;
          phase_d = 2'd3;
        end
        default: begin
          smp_fire = 1'b1;
          done_d   = done_q + SDW'(1);
          phase_d  = 2'd0;
        end
      endcase
    end else begin
      idx_d = idx_q;
    end
    meta_fire = last & kept_d & (done_d != '0);
    if (idx_q != IDX_MAX) begin
      idx_d = idx_q + 16'd1;
    end
  end

  assign cnt_ext = {9'd0, done_d};

  always_comb begin
    smp_res                  = '0;
    smp_res.result_kind      = KIND_SAMPLE;
    smp_res.sample_real      = {held1_q, held0_q};
    smp_res.sample_imag      = {b, held2_q};
    smp_res.sample_frame_end = last;
    smp_res.run_last         = ~meta_fire;
    meta_res                 = '0;
    meta_res.result_kind     = KIND_META;
    meta_res.signal_strength = rssi_d;
    meta_res.sequence_number = seq_d;
    meta_res.core_stream     = core_d;
    meta_res.channel_spec    = chan_d;
    meta_res.sample_count    = cnt_ext[8:0];
    meta_res.run_last        = 1'b1;
  end

  always_comb begin
    push_o.vld0 = adv & (smp_fire | meta_fire);
    push_o.vld1 = adv & smp_fire & meta_fire;
    push_o.res0 = smp_fire ? smp_res : meta_res;
    push_o.res1 = meta_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      etype_q   <= '0;
      proto_q   <= '0;
      port_hi_q <= '0;
      kept_q    <= 1'b1;
      rssi_q    <= '0;
      seq_q     <= '0;
      core_q    <= '0;
      chan_q    <= '0;
      done_q    <= '0;
      held0_q   <= '0;
      held1_q   <= '0;
      held2_q   <= '0;
      phase_q   <= '0;
    end else if (adv) begin
      if (last) begin
        idx_q     <= '0;
        etype_q   <= '0;
        proto_q   <= '0;
        port_hi_q <= '0;
        kept_q    <= 1'b1;
        rssi_q    <= '0;
        seq_q     <= '0;
        core_q    <= '0;
        chan_q    <= '0;
        done_q    <= '0;
        held0_q   <= '0;
        held1_q   <= '0;
        held2_q   <= '0;
        phase_q   <= '0;
      end else begin
        idx_q     <= idx_d;
        etype_q   <= etype_d;
        proto_q   <= proto_d;
        port_hi_q <= port_hi_d;
        kept_q    <= kept_d;
        rssi_q    <= rssi_d;
        seq_q     <= seq_d;
        core_q    <= core_d;
        chan_q    <= chan_d;
        done_q    <= done_d;
        held0_q   <= held0_d;
        held1_q   <= held1_d;
        held2_q   <= held2_d;
        phase_q   <= phase_d;
      end
    end
  end

endmodule

// ----- rtl/ucfp_outq.sv -----
// ============================================================================
// UDP CSI frame parser: result queue
// Four-entry register queue that takes up to two results per cycle and
// presents one beat at a time on the output channel.
// ============================================================================
module ucfp_outq import ucfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  out_beat_t  mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [1:0] n_push;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_beat_o  = mem_q[rd_q];
  assign pop         = out_valid_o & ~out_stall_i;
  assign room_o      = (cnt_q <= 3'd2);
  assign n_push      = {1'b0, push_i.vld0} + {1'b0, push_i.vld1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + {1'b0, pop};
      wr_q  <= wr_q + n_push;
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.vld1) begin
      mem_q[wr_q + 2'd1] <= push_i.res1;
    end
  end

endmodule

// ----- rtl/udp_csi_frame_parser_core.sv -----
// ============================================================================
// UDP CSI frame parser core
// A beat accepted into the input register is parsed, and its results are written
// into the result queue. Throughput: one byte per cycle while the queue has room;
// a frame's final byte may yield two results, which the four-entry result queue
// takes in one push. Reset empties the queue, returns the frame state to its start
// of frame values and clears the port register to zero.
// ============================================================================
module udp_csi_frame_parser_core import ucfp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES   = MAX_SAMPLES_DEF,
  parameter int unsigned PAYLOAD_START = PAYLOAD_START_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] dest_port_q;
  logic        room;
  res_push_t   push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_port_q <= '0;
    end else if (cfg_we_i) begin
      dest_port_q <= cfg_wdata_i;
    end
  end

  ucfp_parse #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .PAYLOAD_START (PAYLOAD_START)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .dest_port_i (dest_port_q),
    .room_i      (room),
    .push_o      (push)
  );

  ucfp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ----- tb/udp_csi_frame_parser_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// UDP CSI frame parser checker
// Watches the byte, result and port-register channels of the parser. Every
// accepted byte is run through a cycle-free copy of the frame parser, which
// queues the sample and metadata beats that the byte should produce. Every
// accepted result beat is compared field by field with the oldest queued beat.
// ============================================================================
module udp_csi_frame_parser_checker import ucfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_beat_t    in_beat_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_beat_t   out_beat_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          due_o,
  output int          fail_cnt_o
);

  logic [15:0] match_port;
  logic [15:0] byte_pos;
  logic [15:0] eth_type;
  logic [7:0]  l4_proto;
  logic [7:0]  dport_hi;
  logic        keep_frame;
  logic [7:0]  rssi;
  logic [15:0] seq_num;
  logic [7:0]  core_byte;
  logic [15:0] chanspec;
  int          samples_out;
  logic [7:0]  part_bytes [3];
  logic [1:0]  part_cnt;

  out_beat_t   expected_beats [$];
  int          fails = 0;

  assign fail_cnt_o = fails;

  function automatic void clear_frame();
    byte_pos      = '0;
    eth_type      = '0;
    l4_proto      = '0;
    dport_hi      = '0;
    keep_frame    = 1'b1;
    rssi          = '0;
    seq_num       = '0;
    core_byte     = '0;
    chanspec      = '0;
    samples_out   = 0;
    part_bytes[0] = '0;
    part_bytes[1] = '0;
    part_bytes[2] = '0;
    part_cnt      = '0;
  endfunction

  task automatic parse_byte(input in_beat_t ib);
    out_beat_t   made [2];
    int          n;
    logic [7:0]  b;
    n = 0;
    b = ib.frame_byte;
    unique case (byte_pos)
      OFS_ETYPE_HI: eth_type[15:8] = b;
      OFS_ETYPE_LO: eth_type[7:0]  = b;
      OFS_L4_PROTO: l4_proto       = b;
      OFS_PORT_HI:  dport_hi       = b;
      OFS_PORT_LO: begin
        keep_frame = (eth_type == ETH_TYPE_IPV4) && (l4_proto == L4_PROTO_UDP) &&
                     ({dport_hi, b} == match_port);
      end
      OFS_RSSI:     rssi           = b;
      OFS_SEQ_LO:   seq_num[7:0]   = b;
      OFS_SEQ_HI:   seq_num[15:8]  = b;
      OFS_CORE:     core_byte      = b;
      OFS_CHAN_LO:  chanspec[7:0]  = b;
      OFS_CHAN_HI:  chanspec[15:8] = b;
      default: begin
        if (byte_pos >= PAYLOAD_START_DEF && keep_frame && samples_out < MAX_SAMPLES_DEF) begin
          if (part_cnt < 2'd3) begin
            part_bytes[part_cnt] = b;
            part_cnt++;
          end else begin
            made[n]                  = '0;
            made[n].result_kind      = KIND_SAMPLE;
            made[n].sample_real      = {part_bytes[1], part_bytes[0]};
            made[n].sample_imag      = {b, part_bytes[2]};
            made[n].sample_frame_end = ib.frame_end;
            n++;
            samples_out++;
            part_cnt = '0;
          end
        end
      end
    endcase

    if (ib.frame_end && keep_frame && samples_out > 0) begin
      made[n]                 = '0;
      made[n].result_kind     = KIND_META;
      made[n].signal_strength = rssi;
      made[n].sequence_number = seq_num;
      made[n].core_stream     = core_byte;
      made[n].channel_spec    = chanspec;
      made[n].sample_count    = samples_out[8:0];
      n++;
    end

    if (n > 0) begin
      made[n-1].run_last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_beats.push_back(made[i]);
    end

    if (ib.frame_end) begin
      clear_frame();
    end else if (byte_pos != IDX_MAX) begin
      byte_pos++;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      match_port = '0;
      clear_frame();
      expected_beats.delete();
      due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        match_port = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_beat_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $error("Result beat arrived with none expected.");
          fails++;
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind", 16'(want.result_kind),
                      16'(out_beat_i.result_kind));
          check_field("sample_real", 16'(want.sample_real),
                      16'(out_beat_i.sample_real));
          check_field("sample_imag", 16'(want.sample_imag),
                      16'(out_beat_i.sample_imag));
          check_field("sample_frame_end", 16'(want.sample_frame_end),
                      16'(out_beat_i.sample_frame_end));
          check_field("signal_strength", 16'(want.signal_strength),
                      16'(out_beat_i.signal_strength));
          check_field("sequence_number", 16'(want.sequence_number),
                      16'(out_beat_i.sequence_number));
          check_field("core_stream", 16'(want.core_stream),
                      16'(out_beat_i.core_stream));
          check_field("channel_spec", 16'(want.channel_spec),
                      16'(out_beat_i.channel_spec));
          check_field("sample_count", 16'(want.sample_count),
                      16'(out_beat_i.sample_count));
          check_field("run_last", 16'(want.run_last), 16'(out_beat_i.run_last));
        end
      end
      due_o <= expected_beats.size();
    end
  end

endmodule

// ----- tb/udp_csi_frame_parser_core_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// UDP CSI frame parser testbench
// Feeds Ethernet frames byte by byte into the parser under random gaps and
// result-side stalls. Directed frames cover short, rejected, partial and
// capped frames; two short random phases mix well-formed UDP frames for other
// port settings with broken headers and noise.
// ============================================================================
module udp_csi_frame_parser_core_tb;
  import ucfp_pkg::*;

  localparam longint unsigned LIMIT_NS = 64'd18_000_000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_beat_t    in_beat   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        press_req = 1'b0;

  logic        in_stall;
  logic        out_valid;
  out_beat_t   out_beat;
  int          results_due;
  int          fail_cnt;

  int          stuck_cnt = 0;
  bit          gaps_on   = 1'b1;
  logic [7:0]  frame_bytes [$];

  udp_csi_frame_parser_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  udp_csi_frame_parser_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .due_o       (results_due),
    .fail_cnt_o  (fail_cnt)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : sink
    int hold;
    int burst;
    int win;
    int mode;
    bit held_off;
    hold     = 0;
    burst    = 0;
    win      = 0;
    mode     = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (press_req && !held_off) begin
        held_off = 1'b1;
        hold     = 400;
      end
      if (win == 0) begin
        mode = $urandom_range(2);
        win  = $urandom_range(200, 20);
      end
      win--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (burst == 0 && mode != 0 && $urandom_range(mode == 2 ? 1 : 5) == 0) begin
          burst = ($urandom_range(15) == 0) ? $urandom_range(30, 10) : $urandom_range(3, 1);
        end
        if (burst > 0) begin
          burst--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (gaps_on && $urandom_range(3) == 0) begin
      gap = ($urandom_range(15) == 0) ? $urandom_range(40, 12) : $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= {b, last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  task automatic build_frame(input int len, input logic [15:0] etype,
                             input logic [7:0] proto, input logic [15:0] port);
    frame_bytes.delete();
    for (int i = 0; i < ((len > 38) ? len : 38); i++) begin
      frame_bytes.push_back(8'($urandom_range(255)));
    end
    frame_bytes[12] = etype[15:8];
    frame_bytes[13] = etype[7:0];
    frame_bytes[23] = proto;
    frame_bytes[36] = port[15:8];
    frame_bytes[37] = port[7:0];
    while (frame_bytes.size() > len) begin
      void'(frame_bytes.pop_back());
    end
  endtask

  task automatic set_word(input int at, input logic [15:0] v);
    frame_bytes[at]   = v[7:0];
    frame_bytes[at+1] = v[15:8];
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_due != 0 && waited < 20000);
    if (results_due != 0) begin
      $error("%0d result beats never arrived.", results_due);
      stuck_cnt++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] port);
    cfg_we    <= 1'b1;
    cfg_wdata <= port;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          sent;
    int          len;
    int          pick;
    logic [15:0] dport;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] fport;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The port register still holds its reset value of zero here.
    build_frame(1, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    send_frame();
    build_frame(30, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    send_frame();
    build_frame(64, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    frame_bytes[44] = 8'h80;
    set_word(52, 16'hFFFF);
    frame_bytes[54] = 8'hFF;
    set_word(56, 16'h0000);
    set_word(60, 16'h8000);
    set_word(62, 16'h7FFF);
    send_frame();
    build_frame(70, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    frame_bytes[44] = 8'h7F;
    set_word(52, 16'h0000);
    frame_bytes[54] = 8'h00;
    set_word(56, 16'hFFFF);
    set_word(60, 16'h7FFF);
    set_word(62, 16'h8000);
    set_word(64, 16'hFFFF);
    set_word(66, 16'h0000);
    send_frame();
    build_frame(38, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    send_frame();
    build_frame(62, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0000);
    send_frame();
    build_frame(64, 16'h0801, L4_PROTO_UDP, 16'h0000);
    send_frame();
    build_frame(64, ETH_TYPE_IPV4, 8'd6, 16'h0000);
    send_frame();
    build_frame(64, ETH_TYPE_IPV4, L4_PROTO_UDP, 16'h0001);
    send_frame();

    // The receiver holds off during this frame, which also hits the sample cap.
    build_frame(PAYLOAD_START_DEF + 4 * MAX_SAMPLES_DEF + 5, ETH_TYPE_IPV4,
                L4_PROTO_UDP, 16'h0000);
    press_req <= 1'b1;
    send_frame();
    settle();

    for (int ph = 0; ph < 2; ph++) begin
      dport = (ph == 0) ? 16'hFFFF : 16'($urandom_range(65535));
      write_port(dport);
      sent = 0;
      while (sent < 20) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          len = $urandom_range(59, 1);
        end else if (pick < 8) begin
          len = $urandom_range(140, 60);
        end else begin
          len = $urandom_range(200, 141);
        end
        etype = ETH_TYPE_IPV4;
        proto = L4_PROTO_UDP;
        fport = dport;
        pick  = $urandom_range(9);
        if (pick == 7) begin
          etype = 16'($urandom_range(65535));
        end else if (pick == 8) begin
          if ($urandom_range(1) == 0) begin
            proto = 8'($urandom_range(255));
          end else begin
            fport = dport ^ (16'h0001 << $urandom_range(15));
          end
        end else if (pick == 9) begin
          etype = 16'($urandom_range(65535));
          proto = 8'($urandom_range(255));
          fport = 16'($urandom_range(65535));
        end
        build_frame(len, etype, proto, fport);
        gaps_on = ($urandom_range(3) != 0);
        send_frame();
        sent += len;
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && stuck_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- udp_csi_frame_parser_core.f -----
rtl/ucfp_pkg.sv
rtl/ucfp_parse.sv
rtl/ucfp_outq.sv
rtl/udp_csi_frame_parser_core.sv
tb/udp_csi_frame_parser_checker.sv
tb/udp_csi_frame_parser_core_tb.sv
